// ===== rtl/core/dtf_pkg.sv =====
package dtf_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WHOLE_W = 31;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DATA_W-1:0] MAX_MAG = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SCALE_RESET = 32'd1000;
  localparam logic [DATA_W-1:0] SCALE_TENTH_RESET = 32'd100;
  localparam logic [DATA_W-1:0] FALLBACK_RESET = 32'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 1'b1;

  // Characters of interest.
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Finished text handed from the parser to the scaling pipeline.
  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [DATA_W-1:0] frac;
    logic negative;
    logic use_fb;
  } fin_t;

  // Unsigned divide by ten through the reciprocal 0xCCCCCCCD, exact for any
  // 32-bit operand.
  function automatic logic [DATA_W-1:0] div10(input logic [DATA_W-1:0] x);
    logic [63:0] prod;
    prod = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
    return {3'd0, prod[63:35]};
  endfunction

endpackage

// ===== rtl/core/dtf_parse.sv =====
module dtf_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_ch,
  input  logic                 in_last,
  input  logic                 in_key_absent,
  input  logic [31:0]          scale,
  input  logic [31:0]          scale_tenth,
  output logic                 fin_valid,
  output dtf_pkg::fin_t        fin,
  input  logic                 fin_ready
);

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_WHOLE,
    PH_FRAC,
    PH_DONE,
    PH_FAIL
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic neg_r, neg_nxt;
  logic [dtf_pkg::WHOLE_W-1:0] whole_r, whole_nxt, whole_sat;
  logic [31:0] frac_r, frac_nxt;
  logic [31:0] unit_r, unit_nxt;
  logic [31:0] tenth_r, tenth_nxt;
  logic fin_valid_r;
  dtf_pkg::fin_t fin_r, fin_nxt;

  logic accept, is_digit, ends_text;
  logic [3:0] digit;
  logic [34:0] whole_acc;
  logic [35:0] frac_add;

  assign accept = in_valid && in_ready;
  assign in_ready = !fin_valid_r || fin_ready;
  assign fin_valid = fin_valid_r;
  assign fin = fin_r;

  assign is_digit = (in_ch >= dtf_pkg::CH_ZERO) && (in_ch <= dtf_pkg::CH_NINE);
  assign digit = 4'(in_ch - dtf_pkg::CH_ZERO);
  assign whole_acc = 35'(whole_r) * 35'd10 + 35'(digit);
  assign whole_sat = (whole_acc > 35'(dtf_pkg::MAX_MAG)) ?
                     dtf_pkg::MAX_MAG[dtf_pkg::WHOLE_W-1:0] : whole_acc[30:0];
  assign frac_add = tenth_r * {32'd0, digit};
  assign ends_text = in_key_absent || in_last;

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt = neg_r;
    whole_nxt = whole_r;
    frac_nxt = frac_r;
    unit_nxt = unit_r;
    tenth_nxt = tenth_r;
    case (phase_r)
      PH_START: begin
        if (in_ch == dtf_pkg::CH_MINUS || in_ch == dtf_pkg::CH_PLUS) begin
          neg_nxt = (in_ch == dtf_pkg::CH_MINUS);
          phase_nxt = PH_SIGNED;
        end else if (is_digit) begin
          whole_nxt = whole_sat;
          phase_nxt = PH_WHOLE;
        end else begin
          phase_nxt = PH_FAIL;
        end
      end
      PH_SIGNED: begin
        if (is_digit) begin
          whole_nxt = whole_sat;
          phase_nxt = PH_WHOLE;
        end else begin
          phase_nxt = PH_FAIL;
        end
      end
      PH_WHOLE: begin
        if (is_digit) begin
          whole_nxt = whole_sat;
        end else if (in_ch == dtf_pkg::CH_POINT) begin
          unit_nxt = scale;
          tenth_nxt = scale_tenth;
          phase_nxt = PH_FRAC;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_FRAC: begin
        // The tenth of the unit is kept ready, so a digit adds the tenth times the digit.
        if (unit_r > 32'd1 && is_digit) begin
          unit_nxt = tenth_r;
          tenth_nxt = dtf_pkg::div10(tenth_r);
          frac_nxt = frac_r + frac_add[31:0];
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    fin_nxt.whole = whole_nxt;
    fin_nxt.frac = frac_nxt;
    fin_nxt.negative = neg_nxt;
    fin_nxt.use_fb = in_key_absent || phase_nxt == PH_START ||
                     phase_nxt == PH_SIGNED || phase_nxt == PH_FAIL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      neg_r <= 1'b0;
      whole_r <= '0;
      frac_r <= '0;
      unit_r <= '0;
      tenth_r <= '0;
      fin_valid_r <= 1'b0;
    end else begin
      if (accept && ends_text) begin
        fin_valid_r <= 1'b1;
        fin_r <= fin_nxt;
        phase_r <= PH_START;
        neg_r <= 1'b0;
        whole_r <= '0;
        frac_r <= '0;
        unit_r <= '0;
        tenth_r <= '0;
      end else begin
        if (fin_ready) begin
          fin_valid_r <= 1'b0;
        end
        if (accept) begin
          phase_r <= phase_nxt;
          neg_r <= neg_nxt;
          whole_r <= whole_nxt;
          frac_r <= frac_nxt;
          unit_r <= unit_nxt;
          tenth_r <= tenth_nxt;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_absent_gives_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_key_absent |=> fin_valid_r && fin_r.use_fb)
    else $error("absent key did not produce a fallback word");

  a_start_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_START |-> whole_r == '0 && !neg_r && frac_r == '0)
    else $error("start phase with leftover text state");
`endif

endmodule

// ===== rtl/core/dtf_scale.sv =====
module dtf_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fin_valid,
  input  dtf_pkg::fin_t        fin,
  output logic                 fin_ready,
  input  logic [31:0]          scale,
  input  logic [31:0]          fallback,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_fixed_value,
  output logic                 out_used_fallback
);

  // Multiply stage.
  logic a_valid_r;
  logic [62:0] prod_r;
  logic [31:0] frac_r;
  logic neg_r, fb_r;
  logic a_ready;

  // Result stage.
  logic out_valid_r;
  logic [31:0] value_r, value_nxt;
  logic used_fb_r;
  logic out_free;

  logic [63:0] mag;
  logic [31:0] mag_clamped;

  assign out_free = !out_valid_r || out_ready;
  assign a_ready = !a_valid_r || out_free;
  assign fin_ready = a_ready;

  assign mag = {1'b0, prod_r} + {32'd0, frac_r};
  assign mag_clamped = (mag > {32'd0, dtf_pkg::MAX_MAG}) ? dtf_pkg::MAX_MAG : mag[31:0];

  always_comb begin
    if (fb_r) begin
      value_nxt = fallback;
    end else if (neg_r) begin
      value_nxt = 32'd0 - mag_clamped;
    end else begin
      value_nxt = mag_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= fin_valid;
      end
      if (out_free) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && fin_valid) begin
      prod_r <= {32'd0, fin.whole} * {31'd0, scale};
      frac_r <= fin.frac;
      neg_r <= fin.negative;
      fb_r <= fin.use_fb;
    end
    if (out_free && a_valid_r) begin
      value_r <= value_nxt;
      used_fb_r <= fb_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_fixed_value = value_r;
  assign out_used_fallback = used_fb_r;

`ifndef SYNTHESIS
  a_parse_never_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !used_fb_r |-> value_r != 32'h8000_0000)
    else $error("parsed result outside the clamped range");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && out_free |=> out_valid_r)
    else $error("multiply stage word lost on its way to the output");
`endif

endmodule

// ===== rtl/core/decimal_text_to_fixed_point.sv =====
// Streaming decimal text to fixed-point converter.
// The input channel carries one character per word (in_ch), with in_last on
// the final character of a value text and in_key_absent for a text with no
// value bound. An optional sign, integer digits (saturating), a '.' and
// fraction digits are parsed; the first other character ends parsing.
// Each text gives one result word: the value times the scale register,
// truncated toward zero and clamped to 2147483647 in magnitude, or the
// fallback register with out_used_fallback set.
// Throughput is one input word per cycle while in_ready is high: each
// character is a single state update. The final word fills the hand-off
// register, then passes a registered 31 x 32 multiply stage and a clamp
// and sign stage. Three registered stages sit between the channels, so
// words keep being accepted while a result waits; when the receiver holds
// out_ready low the stages fill and in_ready drops once the hand-off register
// is occupied and cannot drain. Configuration is written through cfg_we,
// cfg_index and cfg_wdata, by the user only while idle; the block does not
// enforce it. Synchronous reset (rst_n low) sets scale to 1000, fallback to
// 0, clears the parser and empties all stages; no clearing pass is needed.
module decimal_text_to_fixed_point (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_ch,
  input  logic                               in_last,
  input  logic                               in_key_absent,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 out_fixed_value,
  output logic                               out_used_fallback,
  input  logic                               cfg_we,
  input  logic [dtf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_wdata
);

  logic [31:0] scale_r;
  logic [31:0] scale_tenth_r;
  logic [31:0] fallback_r;

  logic fin_valid, fin_ready;
  dtf_pkg::fin_t fin;

  // The tenth of the scale is taken at write time, so the first fraction
  // digit needs no divide in the parser.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= dtf_pkg::SCALE_RESET;
      scale_tenth_r <= dtf_pkg::SCALE_TENTH_RESET;
      fallback_r <= dtf_pkg::FALLBACK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dtf_pkg::REG_SCALE: begin
          scale_r <= cfg_wdata;
          scale_tenth_r <= dtf_pkg::div10(cfg_wdata);
        end
        dtf_pkg::REG_FALLBACK: begin
          fallback_r <= cfg_wdata;
        end
        default: begin
          fallback_r <= fallback_r;
        end
      endcase
    end
  end

  dtf_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_ch         (in_ch),
    .in_last       (in_last),
    .in_key_absent (in_key_absent),
    .scale         (scale_r),
    .scale_tenth   (scale_tenth_r),
    .fin_valid     (fin_valid),
    .fin           (fin),
    .fin_ready     (fin_ready)
  );

  dtf_scale u_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .fin_valid         (fin_valid),
    .fin               (fin),
    .fin_ready         (fin_ready),
    .scale             (scale_r),
    .fallback          (fallback_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fixed_value   (out_fixed_value),
    .out_used_fallback (out_used_fallback)
  );

endmodule
